FILE: hdl/vrrq_pkg.sv
// Shared types and constants for the variable record ring queue.
// Holds the item structs, status codes and the controller/datapath command
// and flag groups. No dependencies.
package vrrq_pkg;

  localparam int RING_BYTES         = 65536;
  localparam int HEAD_AREA_BYTES    = 16;
  localparam int BLOCK_HEADER_BYTES = 32;
  localparam int DESC_DEPTH         = 2048;
  localparam int RING_MIN_BASE      = 64;
  localparam int RING_MIN           = (RING_MIN_BASE > HEAD_AREA_BYTES + BLOCK_HEADER_BYTES) ?
                                      RING_MIN_BASE : HEAD_AREA_BYTES + BLOCK_HEADER_BYTES;

  localparam int RING_W  = 17;
  localparam int OFF_W   = 18;
  localparam int LEN_W   = 16;
  localparam int ID_W    = 64;
  localparam int TYPE_W  = 8;
  localparam int CNT_W   = 12;
  localparam int DESC_AW = $clog2(DESC_DEPTH);

  localparam logic [TYPE_W-1:0] PAD_TYPE = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FAULT = 2'd3
  } status_t;

  typedef struct packed {
    logic              mode;
    logic [LEN_W-1:0]  rec_length;
    logic [ID_W-1:0]   rec_id;
    logic [TYPE_W-1:0] rec_type;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  rec_offset;
    logic [LEN_W-1:0]  out_length;
    logic [ID_W-1:0]   out_id;
    logic [TYPE_W-1:0] out_type;
    logic [CNT_W-1:0]  queued_count;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;
    logic    cfg_wr;
    logic    pad_wr;
    logic    wo_wrap;
    logic    rec_push;
    logic    ro_wrap;
    logic    ri_adv;
    logic    rec_pop;
    logic    finish;
    status_t fin_status;
  } cmd_t;

  // Conditions the datapath reports back
  typedef struct packed {
    logic malformed;
    logic fits;
    logic ro_at_head;
    logic ro_gt_wo;
    logic pad_room;
    logic desc_full;
    logic desc_empty;
    logic blocks;
    logic gap_small;
    logic rd_is_pad;
    logic ro_eq_wo;
  } flags_t;

endpackage

FILE: hdl/vrrq_dpath.sv
// Datapath of the ring queue: offsets, counters, descriptor memories and
// the result register. Acts on vrrq_pkg::cmd_t and reports vrrq_pkg::flags_t.
// Depends on vrrq_pkg.
module vrrq_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vrrq_pkg::cmd_t                   cmd,
  input  vrrq_pkg::in_item_t               in_data,
  input  logic [vrrq_pkg::RING_W-1:0]      cfg_data,
  output vrrq_pkg::flags_t                 flags,
  output vrrq_pkg::out_item_t              out_data
);

  localparam int LT_W = vrrq_pkg::RING_W + vrrq_pkg::TYPE_W;
  localparam logic [vrrq_pkg::OFF_W-1:0] HEAD_OFF =
    vrrq_pkg::OFF_W'(vrrq_pkg::HEAD_AREA_BYTES);
  localparam logic [vrrq_pkg::OFF_W-1:0] HDR_BYTES =
    vrrq_pkg::OFF_W'(vrrq_pkg::BLOCK_HEADER_BYTES);

  function automatic logic [vrrq_pkg::RING_W-1:0] clamp_ring(
    input logic [vrrq_pkg::RING_W-1:0] v
  );
    logic [vrrq_pkg::RING_W-1:0] r;
    r = v;
    if (v < vrrq_pkg::RING_W'(vrrq_pkg::RING_MIN)) begin
      r = vrrq_pkg::RING_W'(vrrq_pkg::RING_MIN);
    end else if (v > vrrq_pkg::RING_W'(vrrq_pkg::RING_BYTES)) begin
      r = vrrq_pkg::RING_W'(vrrq_pkg::RING_BYTES);
    end
    return r;
  endfunction

  logic [vrrq_pkg::RING_W-1:0]  ring_r;
  logic [vrrq_pkg::OFF_W-1:0]   wo_r, wo_nxt;
  logic [vrrq_pkg::OFF_W-1:0]   ro_r, ro_nxt;
  logic [vrrq_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [vrrq_pkg::DESC_AW-1:0] wi_r, wi_nxt;
  logic [vrrq_pkg::DESC_AW-1:0] ri_r, ri_nxt;
  vrrq_pkg::in_item_t           item_r;
  vrrq_pkg::out_item_t          out_r;

  logic [LT_W-1:0]              lt_mem [vrrq_pkg::DESC_DEPTH];
  logic [vrrq_pkg::ID_W-1:0]    id_mem [vrrq_pkg::DESC_DEPTH];
  logic [LT_W-1:0]              rd_lt_r;
  logic [vrrq_pkg::ID_W-1:0]    rd_id_r;

  logic [vrrq_pkg::OFF_W-1:0]   ring_off;
  logic [vrrq_pkg::OFF_W-1:0]   len_off;
  logic [vrrq_pkg::OFF_W-1:0]   surplus;
  logic [vrrq_pkg::OFF_W-1:0]   gap;
  logic [vrrq_pkg::OFF_W-1:0]   wo_end;
  logic [vrrq_pkg::RING_W-1:0]  rd_len;
  logic [vrrq_pkg::TYPE_W-1:0]  rd_type;
  logic                         mem_wr;
  logic [LT_W-1:0]              mem_lt_wd;
  logic [vrrq_pkg::ID_W-1:0]    mem_id_wd;

  assign ring_off = vrrq_pkg::OFF_W'(ring_r);
  assign len_off  = vrrq_pkg::OFF_W'(item_r.rec_length);
  assign surplus  = (ring_off > wo_r) ? ring_off - wo_r : '0;
  assign gap      = (ring_off > ro_r) ? ring_off - ro_r : '0;
  assign wo_end   = wo_r + len_off;
  assign rd_len   = rd_lt_r[LT_W-1:vrrq_pkg::TYPE_W];
  assign rd_type  = rd_lt_r[vrrq_pkg::TYPE_W-1:0];

  always_comb begin
    flags.malformed  = (len_off < HDR_BYTES) || (item_r.rec_type == vrrq_pkg::PAD_TYPE);
    flags.fits       = surplus >= len_off;
    flags.ro_at_head = ro_r == HEAD_OFF;
    flags.ro_gt_wo   = ro_r > wo_r;
    flags.pad_room   = surplus >= HDR_BYTES;
    flags.desc_full  = (wi_r + 1'b1) == ri_r;
    flags.desc_empty = wi_r == ri_r;
    flags.blocks     = (ro_r > wo_r) && (ro_r <= wo_end);
    flags.gap_small  = gap < HDR_BYTES;
    flags.rd_is_pad  = rd_type == vrrq_pkg::PAD_TYPE;
    flags.ro_eq_wo   = ro_r == wo_r;
  end

  // Pad descriptors carry the tail size and a zero id
  assign mem_wr    = cmd.pad_wr || cmd.rec_push;
  assign mem_lt_wd = cmd.pad_wr ? {surplus[vrrq_pkg::RING_W-1:0], vrrq_pkg::PAD_TYPE}
                                : {vrrq_pkg::RING_W'(item_r.rec_length), item_r.rec_type};
  assign mem_id_wd = cmd.pad_wr ? '0 : item_r.rec_id;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      lt_mem[wi_r] <= mem_lt_wd;
      id_mem[wi_r] <= mem_id_wd;
    end
    rd_lt_r <= lt_mem[ri_r];
    rd_id_r <= id_mem[ri_r];
  end

  always_comb begin
    wo_nxt  = wo_r;
    ro_nxt  = ro_r;
    cnt_nxt = cnt_r;
    wi_nxt  = wi_r;
    ri_nxt  = ri_r;
    if (cmd.pad_wr || cmd.rec_push) begin
      wi_nxt = wi_r + 1'b1;
    end
    if (cmd.wo_wrap) begin
      wo_nxt = HEAD_OFF;
    end
    if (cmd.rec_push) begin
      wo_nxt  = wo_end;
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.ro_wrap) begin
      ro_nxt = HEAD_OFF;
    end
    if (cmd.ri_adv || cmd.rec_pop) begin
      ri_nxt = ri_r + 1'b1;
    end
    if (cmd.rec_pop) begin
      ro_nxt = ro_r + vrrq_pkg::OFF_W'(rd_len);
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r <= vrrq_pkg::RING_W'(vrrq_pkg::RING_BYTES);
      wo_r   <= HEAD_OFF;
      ro_r   <= HEAD_OFF;
      cnt_r  <= '0;
      wi_r   <= '0;
      ri_r   <= '0;
    end else if (cmd.cfg_wr) begin
      // new ring size empties the queue
      ring_r <= clamp_ring(cfg_data);
      wo_r   <= HEAD_OFF;
      ro_r   <= HEAD_OFF;
      cnt_r  <= '0;
      wi_r   <= '0;
      ri_r   <= '0;
    end else begin
      wo_r  <= wo_nxt;
      ro_r  <= ro_nxt;
      cnt_r <= cnt_nxt;
      wi_r  <= wi_nxt;
      ri_r  <= ri_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.finish) begin
      out_r.status       <= cmd.fin_status;
      out_r.rec_offset   <= cmd.rec_push ? wo_r[vrrq_pkg::LEN_W-1:0] :
                            cmd.rec_pop  ? ro_r[vrrq_pkg::LEN_W-1:0] : '0;
      out_r.out_length   <= cmd.rec_pop ? rd_len[vrrq_pkg::LEN_W-1:0] : '0;
      out_r.out_id       <= cmd.rec_pop ? rd_id_r : '0;
      out_r.out_type     <= cmd.rec_pop ? rd_type : '0;
      out_r.queued_count <= cnt_nxt;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/vrrq_ctrl.sv
// Controller of the ring queue: sequences the push and pop checks and
// drives vrrq_pkg::cmd_t into the datapath from its vrrq_pkg::flags_t.
// Depends on vrrq_pkg.
module vrrq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_mode,
  input  logic             cfg_valid,
  input  vrrq_pkg::flags_t flags,
  output vrrq_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             cfg_ready,
  output logic             out_strobe
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP1,
    S_BLK1,
    S_WRAP2,
    S_BLK2,
    S_RD1,
    S_EQ1,
    S_RD2,
    S_EQ2,
    S_POP
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r;

  assign busy       = state_r != S_IDLE;
  assign cfg_ready  = (state_r == S_IDLE) && !start;
  assign out_strobe = strobe_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.cfg_wr = cfg_valid && !start;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = in_mode ? S_RD1 : S_WRAP1;
        end
      end
      S_WRAP1, S_WRAP2: begin
        priority if (state_r == S_WRAP1 && flags.malformed) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = vrrq_pkg::ST_FAULT;
        end else if (flags.fits) begin
          state_nxt = (state_r == S_WRAP1) ? S_BLK1 : S_BLK2;
        end else if (flags.ro_at_head) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = vrrq_pkg::ST_FULL;
        end else if (flags.ro_gt_wo) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = vrrq_pkg::ST_FAULT;
        end else if (flags.pad_room && flags.desc_full) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = vrrq_pkg::ST_FULL;
        end else begin
          // wrap to the data start, padding the tail when a header fits
          cmd.pad_wr  = flags.pad_room;
          cmd.wo_wrap = 1'b1;
          state_nxt   = (state_r == S_WRAP1) ? S_BLK1 : S_BLK2;
        end
      end
      S_BLK1: begin
        if (flags.blocks) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = vrrq_pkg::ST_FULL;
        end else begin
          state_nxt = S_WRAP2;
        end
      end
      S_BLK2: begin
        cmd.finish = 1'b1;
        if (flags.blocks || flags.desc_full) begin
          cmd.fin_status = vrrq_pkg::ST_FULL;
        end else begin
          cmd.rec_push   = 1'b1;
          cmd.fin_status = vrrq_pkg::ST_OK;
        end
      end
      S_RD1, S_RD2: begin
        // skip a short tail gap or a pad record ahead of the reader
        if (flags.ro_gt_wo) begin
          if (flags.gap_small) begin
            cmd.ro_wrap = 1'b1;
          end else if (!flags.desc_empty && flags.rd_is_pad) begin
            cmd.ri_adv  = 1'b1;
            cmd.ro_wrap = 1'b1;
          end
        end
        state_nxt = (state_r == S_RD1) ? S_EQ1 : S_EQ2;
      end
      S_EQ1: begin
        if (flags.ro_eq_wo) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = vrrq_pkg::ST_EMPTY;
        end else begin
          state_nxt = S_RD2;
        end
      end
      S_EQ2: begin
        priority if (flags.ro_eq_wo) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = vrrq_pkg::ST_EMPTY;
        end else if (flags.desc_empty) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = vrrq_pkg::ST_FAULT;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cmd.rec_pop    = 1'b1;
        cmd.finish     = 1'b1;
        cmd.fin_status = vrrq_pkg::ST_OK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.finish) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= cmd.finish;
    end
  end

endmodule

FILE: hdl/variable_record_ring_queue_top.sv
// Top level of the variable record ring queue: controller plus datapath.
// Depends on vrrq_pkg, vrrq_ctrl and vrrq_dpath.
//
// Pushes and pops record offsets in a ring of variable-length records. Raise
// start with in_data while busy is low; the item is taken at that edge. The
// result shows on out_data for exactly one cycle with out_strobe high and
// cannot be held off, so capture it when the strobe is seen. A push runs the
// wrap checks, pad write and fit check; a pop runs the pad and gap skipping
// passes, each of which waits for the registered descriptor memory read.
// The strobe comes in the cycle after the last step, with busy already low.
// A ring size write on the cfg channel is taken only while idle and empties
// the queue.
module variable_record_ring_queue_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  vrrq_pkg::in_item_t           in_data,
  output logic                         out_strobe,
  output vrrq_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vrrq_pkg::RING_W-1:0]  cfg_data
);

  vrrq_pkg::cmd_t   cmd;
  vrrq_pkg::flags_t flags;

  vrrq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_mode    (in_data.mode),
    .cfg_valid  (cfg_valid),
    .flags      (flags),
    .cmd        (cmd),
    .busy       (busy),
    .cfg_ready  (cfg_ready),
    .out_strobe (out_strobe)
  );

  vrrq_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_data (cfg_data),
    .flags    (flags),
    .out_data (out_data)
  );

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy && $past(busy))
    else $error("result strobe without a finished item");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

  a_fail_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.status != vrrq_pkg::ST_OK |->
      out_data.rec_offset == '0 && out_data.out_length == '0)
    else $error("failed item reports a record");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pad_wr || cmd.rec_push) |-> !flags.desc_full)
    else $error("descriptor written while full");

endmodule

FILE: sim/variable_record_ring_queue_top_test.sv
// Self-checking test for variable_record_ring_queue_top: directed wrap, pad
// and fault cases, then random push/pop traffic over several ring sizes.
// Depends on vrrq_pkg and the RTL of variable_record_ring_queue_top.
module variable_record_ring_queue_top_test;
  import vrrq_pkg::*;

  localparam int   CYCLE_LIMIT   = 500000;
  localparam int   SETTLE_CYCLES = 8;
  localparam logic MODE_PUSH     = 1'b0;
  localparam logic MODE_POP      = 1'b1;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_data;
  logic                out_strobe;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [RING_W-1:0]   cfg_data;

  variable_record_ring_queue_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Mirror of the ring offsets and the descriptor FIFO
  int unsigned     ring_len;
  int unsigned     wr_off;
  int unsigned     rd_off;
  int unsigned     rec_cnt;
  int unsigned     desc_wr_idx;
  int unsigned     desc_rd_idx;
  int unsigned     desc_len_type [DESC_DEPTH];
  logic [ID_W-1:0] desc_ident [DESC_DEPTH];

  out_item_t awaited_results [$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("variable_record_ring_queue_top_test: errors");
      $finish;
    end
  end

  function automatic void clear_ring_mirror();
    wr_off      = HEAD_AREA_BYTES;
    rd_off      = HEAD_AREA_BYTES;
    rec_cnt     = 0;
    desc_wr_idx = 0;
    desc_rd_idx = 0;
  endfunction

  function automatic int unsigned clamp_ring_len(logic [RING_W-1:0] value);
    int unsigned n;
    n = value;
    if (n < RING_MIN) n = RING_MIN;
    if (n > RING_BYTES) n = RING_BYTES;
    return n;
  endfunction

  function automatic int unsigned desc_step(int unsigned i);
    return (i + 1 >= DESC_DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int unsigned desc_entries();
    if (desc_wr_idx >= desc_rd_idx) return desc_wr_idx - desc_rd_idx;
    return desc_wr_idx + DESC_DEPTH - desc_rd_idx;
  endfunction

  function automatic bit desc_full();
    return desc_entries() >= DESC_DEPTH - 1;
  endfunction

  function automatic void desc_store(int unsigned len, logic [TYPE_W-1:0] typ,
                                     logic [ID_W-1:0] id);
    desc_len_type[desc_wr_idx] = (len << 8) | typ;
    desc_ident[desc_wr_idx]    = id;
    desc_wr_idx                = desc_step(desc_wr_idx);
  endfunction

  // Move the write offset back to the data start when the record does not fit
  function automatic status_t wrap_for_push(int unsigned len);
    int unsigned surplus;
    surplus = (ring_len > wr_off) ? ring_len - wr_off : 0;
    if (surplus >= len) return ST_OK;
    if (rd_off == HEAD_AREA_BYTES) return ST_FULL;
    if (rd_off > wr_off) return ST_FAULT;
    if (surplus >= BLOCK_HEADER_BYTES) begin
      if (desc_full()) return ST_FULL;
      desc_store(surplus, PAD_TYPE, '0);
    end
    wr_off = HEAD_AREA_BYTES;
    return ST_OK;
  endfunction

  function automatic bit write_blocked(int unsigned len);
    return rd_off > wr_off && rd_off <= wr_off + len;
  endfunction

  // Skip a tail gap too short for a header, or a pad record at the tail
  function automatic void skip_tail_for_pop();
    int unsigned gap;
    if (wr_off >= rd_off) return;
    gap = (ring_len > rd_off) ? ring_len - rd_off : 0;
    if (gap < BLOCK_HEADER_BYTES) begin
      rd_off = HEAD_AREA_BYTES;
      return;
    end
    if (desc_entries() > 0 && desc_len_type[desc_rd_idx][7:0] == PAD_TYPE) begin
      desc_rd_idx = desc_step(desc_rd_idx);
      rd_off      = HEAD_AREA_BYTES;
    end
  endfunction

  function automatic out_item_t predict_queue_op(in_item_t it);
    out_item_t   res;
    status_t     st;
    int unsigned len;
    int unsigned lt;
    res = '0;
    st  = ST_OK;
    len = it.rec_length;
    if (it.mode == MODE_PUSH) begin
      if (len < BLOCK_HEADER_BYTES || it.rec_type == PAD_TYPE) begin
        st = ST_FAULT;
      end else begin
        st = wrap_for_push(len);
        if (st == ST_OK && write_blocked(len)) st = ST_FULL;
        if (st == ST_OK) st = wrap_for_push(len);
        if (st == ST_OK && (write_blocked(len) || desc_full())) st = ST_FULL;
        if (st == ST_OK) begin
          desc_store(len, it.rec_type, it.rec_id);
          res.rec_offset = wr_off[LEN_W-1:0];
          wr_off         = wr_off + len;
          rec_cnt        = rec_cnt + 1;
        end
      end
    end else begin
      skip_tail_for_pop();
      if (rd_off == wr_off) begin
        st = ST_EMPTY;
      end else begin
        skip_tail_for_pop();
        if (rd_off == wr_off) begin
          st = ST_EMPTY;
        end else if (desc_entries() == 0) begin
          st = ST_FAULT;
        end else begin
          lt             = desc_len_type[desc_rd_idx];
          res.out_length = lt[23:8];
          res.out_type   = lt[7:0];
          res.out_id     = desc_ident[desc_rd_idx];
          desc_rd_idx    = desc_step(desc_rd_idx);
          res.rec_offset = rd_off[LEN_W-1:0];
          rd_off         = rd_off + (lt >> 8);
          if (rec_cnt > 0) rec_cnt = rec_cnt - 1;
        end
      end
    end
    res.status       = st;
    res.queued_count = rec_cnt[CNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        $error("result with no operation pending: status %0d offset %0d",
               out_data.status, out_data.rec_offset);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.rec_offset !== want.rec_offset) begin
          $error("rec_offset: expected %0d, got %0d", want.rec_offset, out_data.rec_offset);
          mismatches++;
        end
        if (out_data.out_length !== want.out_length) begin
          $error("out_length: expected %0d, got %0d", want.out_length, out_data.out_length);
          mismatches++;
        end
        if (out_data.out_id !== want.out_id) begin
          $error("out_id: expected %h, got %h", want.out_id, out_data.out_id);
          mismatches++;
        end
        if (out_data.out_type !== want.out_type) begin
          $error("out_type: expected %0d, got %0d", want.out_type, out_data.out_type);
          mismatches++;
        end
        if (out_data.queued_count !== want.queued_count) begin
          $error("queued_count: expected %0d, got %0d",
                 want.queued_count, out_data.queued_count);
          mismatches++;
        end
      end
    end
  end

  function automatic in_item_t noise_item();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t push_op(int unsigned len, logic [TYPE_W-1:0] typ,
                                       logic [ID_W-1:0] id);
    in_item_t it;
    it.mode       = MODE_PUSH;
    it.rec_length = len[LEN_W-1:0];
    it.rec_id     = id;
    it.rec_type   = typ;
    return it;
  endfunction

  // Push fields are don't-care on a pop; fill them with noise
  function automatic in_item_t pop_op();
    in_item_t it;
    it      = noise_item();
    it.mode = MODE_POP;
    return it;
  endfunction

  task automatic issue_op(input in_item_t it);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 23) begin
      start   = 1'b0;
      in_data = noise_item();
      @(negedge clk);
    end
    start   = 1'b1;
    in_data = it;
    do @(posedge clk); while (busy);
    awaited_results.push_back(predict_queue_op(it));
  endtask

  task automatic write_ring_length(input logic [RING_W-1:0] value);
    @(negedge clk);
    start = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    ring_len = clamp_ring_len(value);
    clear_ring_mirror();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_empty_and_malformed();
    issue_op(pop_op());
    issue_op(push_op(16'h0000, 8'h00, '0));
    issue_op(push_op(BLOCK_HEADER_BYTES - 1, 8'h01, {$urandom, $urandom}));
    issue_op(push_op(40, PAD_TYPE, {$urandom, $urandom}));
    issue_op(push_op(BLOCK_HEADER_BYTES, 8'h00, '1));
    // needs a wrap while the read offset still sits at the data start
    issue_op(push_op(16'hFFFF, PAD_TYPE - 8'd1, 64'h0123_4567_89ab_cdef));
    issue_op(pop_op());
    issue_op(pop_op());
  endtask

  // Smallest ring: tail gaps are always too short for a pad
  task automatic test_wrap_without_pad();
    write_ring_length('0);
    issue_op(push_op(BLOCK_HEADER_BYTES, 8'h11, {$urandom, $urandom}));
    issue_op(push_op(BLOCK_HEADER_BYTES, 8'h12, {$urandom, $urandom}));
    issue_op(pop_op());
    issue_op(pop_op());
    issue_op(push_op(BLOCK_HEADER_BYTES, 8'h13, {$urandom, $urandom}));
    issue_op(pop_op());
    issue_op(push_op(BLOCK_HEADER_BYTES, 8'h14, {$urandom, $urandom}));
  endtask

  task automatic test_pad_skip_and_fault();
    write_ring_length(17'd128);
    issue_op(push_op(48, 8'h21, {$urandom, $urandom}));
    issue_op(push_op(32, 8'h22, {$urandom, $urandom}));
    issue_op(pop_op());
    issue_op(push_op(40, 8'h23, {$urandom, $urandom}));
    // wrap needed while the tail lies beyond the head
    issue_op(push_op(80, 8'h24, {$urandom, $urandom}));
    issue_op(pop_op());
    issue_op(pop_op());
    issue_op(pop_op());
  endtask

  task automatic run_traffic_phase(input logic [RING_W-1:0] ring_value, input int n_ops,
                                   input int push_pct);
    int unsigned       max_len;
    int unsigned       sel;
    int unsigned       len;
    logic [TYPE_W-1:0] typ;
    write_ring_length(ring_value);
    max_len = ring_len / 3;
    if (max_len < BLOCK_HEADER_BYTES) max_len = BLOCK_HEADER_BYTES;
    if (max_len > 65535) max_len = 65535;
    repeat (n_ops) begin
      if ($urandom_range(99) < push_pct) begin
        sel = $urandom_range(99);
        if (sel < 4) len = $urandom_range(BLOCK_HEADER_BYTES - 1, 0);
        else if (sel < 8) len = $urandom_range(65535, 0);
        else if (sel < 20) len = BLOCK_HEADER_BYTES + 16 * $urandom_range(3);
        else len = $urandom_range(max_len, BLOCK_HEADER_BYTES);
        if ($urandom_range(99) < 3) typ = PAD_TYPE;
        else typ = TYPE_W'($urandom_range(PAD_TYPE - 1, 0));
        issue_op(push_op(len, typ, {$urandom, $urandom}));
      end else begin
        issue_op(pop_op());
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [RING_W-1:0] ring_value;
    int                push_pct;
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: ring_value = (p == 0) ? '1 : RING_W'($urandom_range(256, 64));
        1: ring_value = (p == 1) ? RING_W'(RING_BYTES) : RING_W'($urandom_range(4096, 257));
        2: ring_value = RING_W'($urandom_range(131071, 0));
        default: ring_value = (p == 3) ? RING_W'(RING_MIN) : RING_W'($urandom_range(1024, 64));
      endcase
      case ($urandom_range(3))
        0: push_pct = 35;
        1: push_pct = 55;
        2: push_pct = 70;
        default: push_pct = 85;
      endcase
      steady = (p == 5);
      run_traffic_phase(ring_value, 140, push_pct);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    steady    = 1'b0;
    ring_len  = clamp_ring_len(RING_W'(RING_BYTES));
    clear_ring_mirror();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_malformed();
    test_wrap_without_pad();
    test_pad_skip_and_fault();
    test_random_traffic();

    @(negedge clk);
    start = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("variable_record_ring_queue_top_test: clean");
    end else begin
      $display("variable_record_ring_queue_top_test: errors");
    end
    $finish;
  end

endmodule
